// ----- src/bks_pkg.sv -----
// Shared widths, codes and types for the agent kinematic step block.
// Used by bks_sub, bks_mul, boid_kinematic_step and its bench; depends on nothing.
package bks_pkg;

  localparam int POS_W     = 32;  // Q16.16 position
  localparam int VEL_W     = 18;  // Q2.16 velocity in [-1, 1]
  localparam int ACC_W     = 22;  // Q6.16 acceleration
  localparam int SUM_W     = 23;  // velocity plus acceleration
  localparam int SQ_W      = 46;  // sum of squares, remainder, root work word
  localparam int MAG_W     = 23;  // integer square root of SQ_W bits
  localparam int QUO_W     = 17;  // unit component magnitude, up to 65536
  localparam int MUL_W     = 24;  // shared multiplier operand width
  localparam int PROD_W    = 48;  // shared multiplier product width
  localparam int VTX_W     = 26;  // unit component times half size
  localparam int SIZE_W    = 8;   // shape size register
  localparam int CNT_W     = 5;   // step counter
  localparam int ROOT_STEPS = 23; // one root bit per step

  localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd16;

  // Item operation codes
  typedef enum logic {
    OP_INIT = 1'b0,
    OP_STEP = 1'b1
  } agent_op_t;

  // Result of the shared compare and subtract unit
  typedef struct packed {
    logic [SQ_W-1:0] diff;
    logic            ge;
  } sub_res_t;

endpackage

// ----- src/bks_sub.sv -----
// Shared compare and subtract unit for square root and division steps.
// Depends on bks_pkg for widths and the sub_res_t result type.
module bks_sub
  import bks_pkg::*;
(
  input  logic [SQ_W-1:0] lhs,
  input  logic [SQ_W-1:0] rhs,
  output sub_res_t        res
);

  logic [SQ_W:0] wide;

  // Subtract with a borrow bit; no borrow means lhs >= rhs
  assign wide     = {1'b0, lhs} - {1'b0, rhs};
  assign res.diff = wide[SQ_W-1:0];
  assign res.ge   = ~wide[SQ_W];

endmodule

// ----- src/bks_mul.sv -----
// Shared signed multiplier for the squares and the vertex offsets.
// Depends on bks_pkg for operand and product widths.
module bks_mul
  import bks_pkg::*;
(
  input  logic signed [MUL_W-1:0]  mul_a,
  input  logic signed [MUL_W-1:0]  mul_b,
  output logic signed [PROD_W-1:0] prod
);

  // Full signed product, registered by the caller
  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

endmodule

// ----- src/boid_kinematic_step.sv -----
// Kinematic step of one agent: sequencer around a shared subtract unit.
// Init item: straight to the done state, result registered once the slot is free.
// Update item: two square multiplies, 23 root steps and 2 x 17 quotient steps on
// the shared subtract unit, then two offset multiplies and the done state; a new
// item is taken only after the result has been loaded into the output register.
// Reset (rst, synchronous): position and velocity zero, shape size 16.
module boid_kinematic_step
  import bks_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [SIZE_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     op,
  input  logic signed [15:0]       start_x,
  input  logic signed [15:0]       start_y,
  input  logic signed [VEL_W-1:0]  start_vel_x,
  input  logic signed [VEL_W-1:0]  start_vel_y,
  input  logic signed [ACC_W-1:0]  accel_x,
  input  logic signed [ACC_W-1:0]  accel_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [POS_W-1:0]  pos_x,
  output logic signed [POS_W-1:0]  pos_y,
  output logic signed [VEL_W-1:0]  vel_x,
  output logic signed [VEL_W-1:0]  vel_y,
  output logic signed [POS_W-1:0]  tip_x,
  output logic signed [POS_W-1:0]  tip_y,
  output logic signed [POS_W-1:0]  left_x,
  output logic signed [POS_W-1:0]  left_y,
  output logic signed [POS_W-1:0]  right_x,
  output logic signed [POS_W-1:0]  right_y
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQX  = 4'd1;
  localparam logic [3:0] S_SQY  = 4'd2;
  localparam logic [3:0] S_ROOT = 4'd3;
  localparam logic [3:0] S_DIVX = 4'd4;
  localparam logic [3:0] S_DIVY = 4'd5;
  localparam logic [3:0] S_MULA = 4'd6;
  localparam logic [3:0] S_MULB = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]              state;
  logic [CNT_W-1:0]        cnt;
  logic                    op_r;
  logic [SIZE_W-1:0]       shape_size;
  logic [POS_W-1:0]        position_x;
  logic [POS_W-1:0]        position_y;
  logic [VEL_W-1:0]        velocity_x;
  logic [VEL_W-1:0]        velocity_y;
  logic signed [SUM_W-1:0] vx;
  logic signed [SUM_W-1:0] vy;
  logic [SQ_W-1:0]         rem;
  logic [SQ_W-1:0]         root;
  logic [QUO_W-2:0]        quo;
  logic [VEL_W-1:0]        ux_r;
  logic [VEL_W-1:0]        uy_r;
  logic [VTX_W-1:0]        prod_a;
  logic [VTX_W-1:0]        prod_b;

  logic signed [SUM_W-1:0]  vx_next;
  logic signed [SUM_W-1:0]  vy_next;
  logic [SUM_W-1:0]         abs_vx;
  logic [SUM_W-1:0]         abs_vy;
  logic [SQ_W-1:0]          bitv;
  logic [SQ_W-1:0]          cand;
  logic [SQ_W-1:0]          sub_lhs;
  logic [SQ_W-1:0]          sub_rhs;
  sub_res_t                 sub_res;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [QUO_W-1:0]         quo_full;
  logic [VEL_W-1:0]         quo_mag;
  logic [VEL_W-1:0]         unit_next;
  logic                     mag_zero;
  logic [SIZE_W-1:0]        half_size;
  logic                     out_load;
  logic [POS_W-1:0]         px_new;
  logic [POS_W-1:0]         py_new;
  logic [POS_W-1:0]         a32;
  logic [POS_W-1:0]         b32;
  logic [POS_W-1:0]         ah;
  logic [POS_W-1:0]         bh;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // Velocity plus acceleration, both sign extended
  assign vx_next = SUM_W'(signed'(velocity_x)) + SUM_W'(accel_x);
  assign vy_next = SUM_W'(signed'(velocity_y)) + SUM_W'(accel_y);
  assign abs_vx  = vx[SUM_W-1] ? SUM_W'(-vx) : SUM_W'(vx);
  assign abs_vy  = vy[SUM_W-1] ? SUM_W'(-vy) : SUM_W'(vy);

  // Root step bit and division candidate remainder
  assign bitv     = SQ_W'(1) << {cnt, 1'b0};
  assign cand     = (cnt == CNT_W'(QUO_W - 1)) ? rem : {rem[SQ_W-2:0], 1'b0};
  assign mag_zero = (root[MAG_W-1:0] == '0);

  // Signed unit component from the finished quotient
  assign quo_full  = {quo, sub_res.ge};
  assign quo_mag   = {1'b0, quo_full};
  assign half_size = {1'b0, shape_size[SIZE_W-1:1]};

  always_comb begin
    unit_next = '0;
    if (!mag_zero) begin
      if (state == S_DIVX) begin
        unit_next = vx[SUM_W-1] ? VEL_W'(-quo_mag) : quo_mag;
      end else begin
        unit_next = vy[SUM_W-1] ? VEL_W'(-quo_mag) : quo_mag;
      end
    end
  end

  // Select operands of the shared subtract unit
  always_comb begin
    sub_lhs = cand;
    sub_rhs = {{(SQ_W-MAG_W){1'b0}}, root[MAG_W-1:0]};
    if (state == S_ROOT) begin
      sub_lhs = rem;
      sub_rhs = root + bitv;
    end
  end

  bks_sub u_sub (
    .lhs (sub_lhs),
    .rhs (sub_rhs),
    .res (sub_res)
  );

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQX: begin
        mul_a = MUL_W'(vx);
        mul_b = MUL_W'(vx);
      end
      S_SQY: begin
        mul_a = MUL_W'(vy);
        mul_b = MUL_W'(vy);
      end
      S_MULA: begin
        mul_a = MUL_W'(signed'(ux_r));
        mul_b = MUL_W'(half_size);
      end
      S_MULB: begin
        mul_a = -MUL_W'(signed'(uy_r));
        mul_b = MUL_W'(half_size);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bks_mul u_mul (
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  // New position and triangle vertices
  assign px_new = position_x + {{(POS_W-VEL_W){ux_r[VEL_W-1]}}, ux_r};
  assign py_new = position_y + {{(POS_W-VEL_W){uy_r[VEL_W-1]}}, uy_r};
  assign a32    = {{(POS_W-VTX_W){prod_a[VTX_W-1]}}, prod_a};
  assign b32    = {{(POS_W-VTX_W){prod_b[VTX_W-1]}}, prod_b};
  assign ah     = {a32[POS_W-1], a32[POS_W-1:1]};
  assign bh     = {b32[POS_W-1], b32[POS_W-1:1]};

  // Sequencer and agent state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      op_r       <= 1'b0;
      shape_size <= SIZE_RESET;
      position_x <= '0;
      position_y <= '0;
      velocity_x <= '0;
      velocity_y <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        shape_size <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= op;
            if (op == OP_INIT) begin
              position_x <= {start_x, 16'b0};
              position_y <= {start_y, 16'b0};
              velocity_x <= start_vel_x;
              velocity_y <= start_vel_y;
              state      <= S_DONE;
            end else begin
              state <= S_SQX;
            end
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          cnt   <= CNT_W'(ROOT_STEPS - 1);
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (cnt == '0) begin
            cnt   <= CNT_W'(QUO_W - 1);
            state <= S_DIVX;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DIVX: begin
          if (cnt == '0) begin
            cnt   <= CNT_W'(QUO_W - 1);
            state <= S_DIVY;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DIVY: begin
          if (cnt == '0) begin
            state <= S_MULA;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_MULA: state <= S_MULB;
        S_MULB: state <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            if (op_r == OP_STEP) begin
              position_x <= px_new;
              position_y <= py_new;
              velocity_x <= ux_r;
              velocity_y <= uy_r;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath work registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        vx <= vx_next;
        vy <= vy_next;
      end
      S_SQX: rem <= prod[SQ_W-1:0];
      S_SQY: begin
        rem  <= rem + prod[SQ_W-1:0];
        root <= '0;
      end
      S_ROOT: begin
        if (sub_res.ge) begin
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        // Load the x dividend after the last root step
        if (cnt == '0) begin
          rem <= {{(SQ_W-SUM_W){1'b0}}, abs_vx};
        end else if (sub_res.ge) begin
          rem <= sub_res.diff;
        end
      end
      S_DIVX, S_DIVY: begin
        quo <= {quo[QUO_W-3:0], sub_res.ge};
        // Load the y dividend after the last x quotient step
        if (cnt == '0 && state == S_DIVX) begin
          rem <= {{(SQ_W-SUM_W){1'b0}}, abs_vy};
        end else begin
          rem <= sub_res.ge ? sub_res.diff : cand;
        end
        if (cnt == '0) begin
          if (state == S_DIVX) begin
            ux_r <= unit_next;
          end else begin
            uy_r <= unit_next;
          end
        end
      end
      S_MULA: prod_a <= prod[VTX_W-1:0];
      S_MULB: prod_b <= prod[VTX_W-1:0];
      default: begin
      end
    endcase
  end

  // Output register, loaded when the result slot is free
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (op_r == OP_STEP) begin
        pos_x   <= px_new;
        pos_y   <= py_new;
        vel_x   <= ux_r;
        vel_y   <= uy_r;
        tip_x   <= px_new + a32;
        tip_y   <= py_new - b32;
        left_x  <= px_new - a32 - bh;
        left_y  <= py_new + bh - ah;
        right_x <= px_new - a32 + bh;
        right_y <= py_new + bh + ah;
      end else begin
        pos_x   <= position_x;
        pos_y   <= position_y;
        vel_x   <= velocity_x;
        vel_y   <= velocity_y;
        tip_x   <= '0;
        tip_y   <= '0;
        left_x  <= '0;
        left_y  <= '0;
        right_x <= '0;
        right_y <= '0;
      end
    end
  end

endmodule

// ----- tb/boid_kinematic_step_tb.sv -----
// Self-checking bench for boid_kinematic_step: init and update items with a
// bit-exact position, unit velocity and triangle predictor under random stalls.
// Depends on bks_pkg and the boid_kinematic_step RTL.
module boid_kinematic_step_tb;
  import bks_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int          ITEMS_PER_PHASE = 175;
  localparam int          NUM_PHASES = 10;
  localparam int          REPORT_CAP = 100;

  typedef struct {
    agent_op_t        op;
    logic [15:0]      start_x;
    logic [15:0]      start_y;
    logic [VEL_W-1:0] start_vel_x;
    logic [VEL_W-1:0] start_vel_y;
    logic [ACC_W-1:0] accel_x;
    logic [ACC_W-1:0] accel_y;
  } agent_item_t;

  typedef struct {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [VEL_W-1:0] vel_x;
    logic [VEL_W-1:0] vel_y;
    logic [POS_W-1:0] tip_x;
    logic [POS_W-1:0] tip_y;
    logic [POS_W-1:0] left_x;
    logic [POS_W-1:0] left_y;
    logic [POS_W-1:0] right_x;
    logic [POS_W-1:0] right_y;
  } step_result_t;

  // Tracks the agent state and the queue of predicted step results
  class agent_tracker;
    logic [SIZE_W-1:0] size = SIZE_RESET;
    logic [POS_W-1:0]  pos_x = '0;
    logic [POS_W-1:0]  pos_y = '0;
    logic [VEL_W-1:0]  vel_x = '0;
    logic [VEL_W-1:0]  vel_y = '0;
    step_result_t      expected_steps[$];
    int                fails = 0;
    int                reports = 0;

    function int pending();
      return expected_steps.size();
    endfunction

    // Largest r with r*r <= n, one result bit at a time from the top
    function longint floor_root(longint unsigned n);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
        trial = root | (64'd1 << i);
        if (trial * trial <= n) root = trial;
      end
      return longint'(root);
    endfunction

    // Advance the agent by one accepted item and queue its result
    function void take_item(agent_item_t it);
      longint sx, sy, ux, uy, mag, h, a, b, ah, bh;
      longint unsigned sq;
      step_result_t exp_res;
      if (it.op == OP_INIT) begin
        pos_x = {it.start_x, 16'h0000};
        pos_y = {it.start_y, 16'h0000};
        vel_x = it.start_vel_x;
        vel_y = it.start_vel_y;
        exp_res = '{pos_x, pos_y, vel_x, vel_y, 0, 0, 0, 0, 0, 0};
      end else begin
        sx = $signed(vel_x) + $signed(it.accel_x);
        sy = $signed(vel_y) + $signed(it.accel_y);
        sq = sx * sx + sy * sy;
        ux = 0;
        uy = 0;
        // zero magnitude keeps the velocity at zero
        if (sq != 0) begin
          mag = floor_root(sq);
          ux = (sx * 65536) / mag;
          uy = (sy * 65536) / mag;
        end
        vel_x = ux[VEL_W-1:0];
        vel_y = uy[VEL_W-1:0];
        pos_x = pos_x + ux[31:0];
        pos_y = pos_y + uy[31:0];
        h = longint'(size >> 1);
        a = ux * h;
        b = -uy * h;
        ah = a >>> 1;
        bh = b >>> 1;
        exp_res.pos_x   = pos_x;
        exp_res.pos_y   = pos_y;
        exp_res.vel_x   = vel_x;
        exp_res.vel_y   = vel_y;
        exp_res.tip_x   = pos_x + a[31:0];
        exp_res.tip_y   = pos_y - b[31:0];
        exp_res.left_x  = pos_x - a[31:0] - bh[31:0];
        exp_res.left_y  = pos_y + bh[31:0] - ah[31:0];
        exp_res.right_x = pos_x - a[31:0] + bh[31:0];
        exp_res.right_y = pos_y + bh[31:0] + ah[31:0];
      end
      expected_steps.push_back(exp_res);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        fails++;
        // limit log size on a badly broken block
        if (reports < REPORT_CAP) begin
          reports++;
          $display("%0t %s: expected %h, actual %h", $time, name, exp_v, got_v);
        end
      end
    endfunction

    // Check one result transfer against the oldest prediction
    function void match_result(step_result_t got);
      step_result_t exp_res;
      if (expected_steps.size() == 0) begin
        fails++;
        $display("%0t unexpected result: expected none, actual pos %h %h",
                 $time, got.pos_x, got.pos_y);
        return;
      end
      exp_res = expected_steps.pop_front();
      compare_field("pos_x", exp_res.pos_x, got.pos_x);
      compare_field("pos_y", exp_res.pos_y, got.pos_y);
      compare_field("vel_x", 32'(exp_res.vel_x), 32'(got.vel_x));
      compare_field("vel_y", 32'(exp_res.vel_y), 32'(got.vel_y));
      compare_field("tip_x", exp_res.tip_x, got.tip_x);
      compare_field("tip_y", exp_res.tip_y, got.tip_y);
      compare_field("left_x", exp_res.left_x, got.left_x);
      compare_field("left_y", exp_res.left_y, got.left_y);
      compare_field("right_x", exp_res.right_x, got.right_x);
      compare_field("right_y", exp_res.right_y, got.right_y);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [SIZE_W-1:0]       cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    op = 1'b0;
  logic signed [15:0]      start_x = '0;
  logic signed [15:0]      start_y = '0;
  logic signed [VEL_W-1:0] start_vel_x = '0;
  logic signed [VEL_W-1:0] start_vel_y = '0;
  logic signed [ACC_W-1:0] accel_x = '0;
  logic signed [ACC_W-1:0] accel_y = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [POS_W-1:0] pos_x, pos_y, tip_x, tip_y;
  logic signed [POS_W-1:0] left_x, left_y, right_x, right_y;
  logic signed [VEL_W-1:0] vel_x, vel_y;

  agent_tracker tracker;
  logic         steady = 1'b0;
  int unsigned  cycle_count = 0;

  boid_kinematic_step DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .start_x(start_x), .start_y(start_y),
    .start_vel_x(start_vel_x), .start_vel_y(start_vel_y),
    .accel_x(accel_x), .accel_y(accel_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
    .tip_x(tip_x), .tip_y(tip_y), .left_x(left_x), .left_y(left_y),
    .right_x(right_x), .right_y(right_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up on a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stall the result side at random outside the steady phase
  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 24);
  end

  // Check every result transfer
  always @(posedge clk) begin
    step_result_t seen;
    if (!rst && out_valid && out_ready) begin
      seen = '{pos_x, pos_y, vel_x, vel_y, tip_x, tip_y, left_x, left_y,
               right_x, right_y};
      tracker.match_result(seen);
    end
  end

  function automatic agent_item_t make_item(agent_op_t o, int sx, int sy, int svx,
                                            int svy, int ax, int ay);
    agent_item_t it;
    it.op          = o;
    it.start_x     = sx[15:0];
    it.start_y     = sy[15:0];
    it.start_vel_x = svx[VEL_W-1:0];
    it.start_vel_y = svy[VEL_W-1:0];
    it.accel_x     = ax[ACC_W-1:0];
    it.accel_y     = ay[ACC_W-1:0];
    return it;
  endfunction

  function automatic logic [VEL_W-1:0] pick_start_vel();
    int v;
    int sel;
    sel = $urandom_range(99);
    if (sel < 65) v = int'($urandom_range(131072)) - 65536;
    else if (sel < 90) v = $urandom;
    else v = 0;
    return v[VEL_W-1:0];
  endfunction

  // Mix in-range, full-width, tiny, zero, cancelling and extreme accelerations
  function automatic logic [ACC_W-1:0] pick_accel(logic [VEL_W-1:0] cur);
    int v;
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) v = int'($urandom_range(2097152)) - 1048576;
    else if (sel < 60) v = $urandom;
    else if (sel < 75) v = int'($urandom_range(512)) - 256;
    else if (sel < 85) v = 0;
    else if (sel < 92) v = -int'($signed(cur));
    else begin
      case ($urandom_range(3))
        0: v = -2097152;
        1: v = 2097151;
        2: v = 1048576;
        default: v = -1048576;
      endcase
    end
    return v[ACC_W-1:0];
  endfunction

  function automatic agent_item_t random_item();
    agent_item_t it;
    it.op          = ($urandom_range(99) < 12) ? OP_INIT : OP_STEP;
    it.start_x     = 16'($urandom);
    it.start_y     = 16'($urandom);
    it.start_vel_x = pick_start_vel();
    it.start_vel_y = pick_start_vel();
    // now and then cancel the whole velocity to reach zero magnitude
    if ($urandom_range(99) < 4) begin
      it.accel_x = -{{(ACC_W-VEL_W){tracker.vel_x[VEL_W-1]}}, tracker.vel_x};
      it.accel_y = -{{(ACC_W-VEL_W){tracker.vel_y[VEL_W-1]}}, tracker.vel_y};
    end else begin
      it.accel_x = pick_accel(tracker.vel_x);
      it.accel_y = pick_accel(tracker.vel_y);
    end
    return it;
  endfunction

  // Present one item, with an optional gap first, and hold it until transfer
  task automatic send_item(agent_item_t it);
    if (!steady && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(70, 1)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= it.op;
    start_x     <= it.start_x;
    start_y     <= it.start_y;
    start_vel_x <= it.start_vel_x;
    start_vel_y <= it.start_vel_y;
    accel_x     <= it.accel_x;
    accel_y     <= it.accel_y;
    do @(posedge clk); while (!in_ready);
    tracker.take_item(it);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.size = value;
  endtask

  initial begin
    agent_item_t       directed[$];
    logic [SIZE_W-1:0] size_plan[7];
    logic [SIZE_W-1:0] size_now;
    tracker = new;
    size_plan = '{8'd255, 8'd0, 8'd1, 8'd2, 8'd3, 8'd128, 8'd254};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset shape size
    directed.push_back(make_item(OP_STEP, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(OP_INIT, 32767, -32768, 65536, -65536, 0, 0));
    directed.push_back(make_item(OP_STEP, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(OP_STEP, 0, 0, 0, 0, 1048576, -1048576));
    directed.push_back(make_item(OP_INIT, -32768, 32767, -131072, 131071, 0, 0));
    directed.push_back(make_item(OP_STEP, 0, 0, 0, 0, -2097152, 2097151));
    directed.push_back(make_item(OP_STEP, 0, 0, 0, 0, 2097151, -2097152));
    directed.push_back(make_item(OP_INIT, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(OP_STEP, 0, 0, 0, 0, 1, 0));
    directed.push_back(make_item(OP_STEP, 0, 0, 0, 0, -65536, 0));
    directed.push_back(make_item(OP_STEP, 0, 0, 0, 0, 0, -1));
    directed.push_back(make_item(OP_INIT, 32767, 0, 65536, 0, 0, 0));
    directed.push_back(make_item(OP_STEP, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(OP_INIT, 0, -32768, 0, -65536, 0, 0));
    directed.push_back(make_item(OP_STEP, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(OP_STEP, 0, 0, 0, 0, 3, 4));
    directed.push_back(make_item(OP_STEP, -1, -1, -1, -1, 300000, 400000));
    directed.push_back(make_item(OP_INIT, -1, -1, -1, -1, -1, -1));
    directed.push_back(make_item(OP_STEP, -1, -1, -1, -1, -1, -1));
    foreach (directed[i]) send_item(directed[i]);
    drain();

    // Random phases, each at its own shape size; one phase runs without stalls
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      size_now = (phase < 7) ? size_plan[phase] : SIZE_W'($urandom_range(255));
      write_size(size_now);
      steady <= (phase == 4);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(random_item());
      drain();
    end

    steady <= 1'b0;
    repeat (70) @(posedge clk);
    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/bks_pkg.sv
src/bks_sub.sv
src/bks_mul.sv
src/boid_kinematic_step.sv
tb/boid_kinematic_step_tb.sv
